/* design/lph_pkg.sv */
// shared types, codes and defaults for the linear probe hash table
package lph_pkg;

   localparam int KEY_W              = 31;
   localparam int HANDLE_W           = 32;
   localparam int SLOT_IDX_W         = 7;
   localparam int SLOTS_DEFAULT      = 128;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]          operation;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] record_handle;
   } lph_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [HANDLE_W-1:0]   found_handle;
      logic [SLOT_IDX_W-1:0] slot_index;
   } lph_rsp_type;

endpackage

/* design/linear_probe_hash_table_top.sv */
// top level of the linear probe hash table
//
// channel  direction  handshake            payload
// req      in         req_push / req_full    lph_req_type (operation, key, record_handle)
// rsp      out        rsp_pop / rsp_empty    lph_rsp_type (status, found_handle, slot_index)
//
// after reset the store is swept clear, one slot a cycle, with req_full high
// front: low key bits as home slot for power-of-two SLOTS, else reciprocal multiply
// back: takes an item, then probes one slot a cycle, up to SLOTS slots,
//   set by the single read port of the slot store
// a result waits in the output register; the back part starts no new item until it is
//   taken, while the front part and the queue keep accepting
module linear_probe_hash_table_top #(
   parameter int SLOTS       = lph_pkg::SLOTS_DEFAULT,
   parameter int QUEUE_DEPTH = lph_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  lph_pkg::lph_req_type req_item,
   output logic                 req_full,
   input  logic                 rsp_pop,
   output lph_pkg::lph_rsp_type rsp_item,
   output logic                 rsp_empty
);

   import lph_pkg::*;

   // queue item: operation-valid flag, home slot, original item
   localparam int Q_W = 1 + $clog2(SLOTS) + $bits(lph_req_type);

   logic           front_full;
   logic           clearing;
   logic           accept;
   logic           q_push;
   logic           q_ready;
   logic [Q_W-1:0] q_in;
   logic [Q_W-1:0] q_out;
   logic           q_valid;
   logic           q_pop;

   // no item is taken during the clearing sweep
   assign req_full = front_full || clearing;
   assign accept   = req_push && !req_full;

   lph_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .full     (front_full),
      .q_push   (q_push),
      .q_data   (q_in),
      .q_ready  (q_ready)
   );

   // decouples hashing from probing
   lph_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .ready     (q_ready),
      .pop       (q_pop),
      .pop_data  (q_out),
      .valid     (q_valid)
   );

   // probe engine, slot store and output register
   lph_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item),
      .clearing  (clearing)
   );

`ifndef SYNTHESIS
   // no result can exist while the store is still being cleared
   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      clearing |-> rsp_empty)
      else $error("result present during clearing sweep");

   // status is always a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_item.status == ST_OK || rsp_item.status == ST_MISS ||
                      rsp_item.status == ST_FULL))
      else $error("undefined status code");

   // misses and full walks carry no handle and no slot
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.status != ST_OK) |->
      (rsp_item.found_handle == '0 && rsp_item.slot_index == '0))
      else $error("non-zero fields on a miss or full result");

   // the queue is never popped while the clearing sweep runs
   a_clear_no_queue: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("queue popped during clearing sweep");
`endif

endmodule

/* design/lph_ram.sv */
// generic simple dual port ram with registered read
module lph_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lph_queue.sv */
// small flip-flop fifo between the front and back parts
module lph_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             ready,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign ready    = (count_ff != CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && ready;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/lph_front.sv */
// front part: takes an item, works out its home slot and checks the operation
module lph_front #(
   parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  lph_pkg::lph_req_type         req_item,
   output logic                         full,
   output logic                         q_push,
   output logic [$bits(lph_pkg::lph_req_type) + $clog2(SLOTS):0] q_data,
   input  logic                         q_ready
);

   import lph_pkg::*;

   localparam int  IDX_W  = $clog2(SLOTS);
   localparam bit  POW2   = ((SLOTS & (SLOTS - 1)) == 0);
   localparam int  PROD_W = 2 * KEY_W;
   localparam int  SH2    = (IDX_W > 0) ? IDX_W - 1 : 0;
   // reciprocal so that key / SLOTS is exact from one multiply, a subtract, an add and shifts
   localparam longint unsigned RECIP =
      ((((64'd1 << IDX_W) - 64'(SLOTS)) << KEY_W) / 64'(SLOTS)) + 64'd1;
   localparam logic [KEY_W:0] RECIP_C = (KEY_W + 1)'(RECIP);

   // steps after an item is taken: product, quotient, remainder
   localparam logic [1:0] STEP_MUL = 2'd3;
   localparam logic [1:0] STEP_QUO = 2'd2;
   localparam logic [1:0] STEP_REM = 2'd1;

   logic              hold_valid_ff, hold_valid_in;
   lph_req_type       hold_ff, hold_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [KEY_W-1:0]  t_ff, t_in;
   logic [KEY_W-1:0]  quo_ff, quo_in;
   logic [1:0]        step_ff, step_in;
   logic [PROD_W-1:0] prod;
   logic [KEY_W-1:0]  quo_calc;
   logic [IDX_W-1:0]  qd_low;
   logic [IDX_W-1:0]  home;
   logic              done;
   logic              op_ok;
   logic              leave;

   // key mod SLOTS by reciprocal multiplication, one stage a cycle
   assign prod     = PROD_W'(RECIP_C) * PROD_W'(hold_ff.key);
   assign quo_calc = (t_ff + ((hold_ff.key - t_ff) >> 1)) >> SH2;
   // the remainder fits in IDX_W bits, so only the low product bits matter
   assign qd_low   = quo_ff[IDX_W-1:0] * IDX_W'(SLOTS);

   assign done  = POW2 ? 1'b1 : (step_ff == '0);
   assign home  = POW2 ? hold_ff.key[IDX_W-1:0] : rem_ff;
   assign op_ok = (hold_ff.operation == OP_INSERT) || (hold_ff.operation == OP_SEARCH) ||
                  (hold_ff.operation == OP_REMOVE);

   assign leave  = hold_valid_ff && done && q_ready;
   assign q_push = leave;
   assign q_data = {op_ok, home, hold_ff};
   assign full   = hold_valid_ff && !(done && q_ready);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rem_in        = rem_ff;
      t_in          = t_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_in       = req_item;
         step_in       = STEP_MUL;
      end else begin
         if (leave) begin
            hold_valid_in = 1'b0;
         end
         if (hold_valid_ff && !done) begin
            case (step_ff)
               STEP_MUL: begin
                  t_in    = prod[PROD_W-1:KEY_W];
                  step_in = STEP_QUO;
               end
               STEP_QUO: begin
                  quo_in  = quo_calc;
                  step_in = STEP_REM;
               end
               STEP_REM: begin
                  rem_in  = hold_ff.key[IDX_W-1:0] - qd_low;
                  step_in = '0;
               end
               default: begin
                  step_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
      rem_ff  <= rem_in;
      t_ff    <= t_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

endmodule

/* design/lph_back.sv */
// back part: clears the table after reset, walks the probe chain, updates slots
module lph_back #(
   parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  logic [$bits(lph_pkg::lph_req_type) + $clog2(SLOTS):0] q_data,
   output logic                         q_pop,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output lph_pkg::lph_rsp_type         rsp_item,
   output logic                         clearing
);

   import lph_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int REQ_W  = $bits(lph_req_type);
   localparam int WIDE_W = (IDX_W > SLOT_IDX_W) ? IDX_W : SLOT_IDX_W;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_PROBE = 2'd2;

   typedef struct packed {
      logic                used;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    steps_ff, steps_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                out_valid_ff, out_valid_in;
   lph_rsp_type         out_ff, out_in;

   lph_req_type         q_req;
   logic [IDX_W-1:0]    q_home;
   logic                q_ok;
   logic                out_free;
   logic [IDX_W-1:0]    nxt;
   logic [WIDE_W-1:0]   cur_wide;
   entry_type           rd_entry;
   logic [$bits(entry_type)-1:0] rd_raw;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_entry;
   logic [IDX_W-1:0]    rd_addr;

   assign q_req    = q_data[REQ_W-1:0];
   assign q_home   = q_data[REQ_W +: IDX_W];
   assign q_ok     = q_data[REQ_W + IDX_W];
   assign out_free = !out_valid_ff || rsp_pop;
   assign nxt      = (cur_ff == IDX_W'(SLOTS - 1)) ? '0 : cur_ff + 1'b1;
   assign cur_wide = WIDE_W'(cur_ff);
   assign rd_entry = rd_raw;

   lph_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      handle_in    = handle_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_entry     = '0;
      rd_addr      = q_home;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop     = 1'b1;
               op_in     = q_req.operation;
               key_in    = q_req.key;
               handle_in = q_req.record_handle;
               cur_in    = q_home;
               steps_in  = '0;
               if (q_ok) begin
                  state_in = S_PROBE;
               end else begin
                  // undefined operation answers a miss at once
                  out_valid_in        = 1'b1;
                  out_in.status       = ST_MISS;
                  out_in.found_handle = '0;
                  out_in.slot_index   = '0;
               end
            end
         end
         S_PROBE: begin
            rd_addr = nxt;
            if (!rd_entry.used || (rd_entry.key == key_ff)) begin
               state_in            = S_IDLE;
               out_valid_in        = 1'b1;
               out_in.status       = ST_OK;
               out_in.found_handle = '0;
               out_in.slot_index   = cur_wide[SLOT_IDX_W-1:0];
               if (op_ff == OP_INSERT) begin
                  wr_en           = 1'b1;
                  wr_entry.used   = 1'b1;
                  wr_entry.key    = key_ff;
                  wr_entry.handle = handle_ff;
               end else if (!rd_entry.used) begin
                  out_in.status     = ST_MISS;
                  out_in.slot_index = '0;
               end else if (op_ff == OP_SEARCH) begin
                  out_in.found_handle = rd_entry.handle;
               end else begin
                  // remove frees the slot, no tombstone
                  wr_en = 1'b1;
               end
            end else if (steps_ff == IDX_W'(SLOTS - 1)) begin
               state_in            = S_IDLE;
               out_valid_in        = 1'b1;
               out_in.status       = ST_FULL;
               out_in.found_handle = '0;
               out_in.slot_index   = '0;
            end else begin
               cur_in   = nxt;
               steps_in = steps_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      handle_ff <= handle_in;
      out_ff    <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;
   assign clearing  = (state_ff == S_CLEAR);

endmodule

/* sim/linear_probe_hash_table_top_tb.sv */
// testbench for the linear probe hash table: directed and random operations, shadow table check
`timescale 1ns / 100ps

module linear_probe_hash_table_top_tb;
   import lph_pkg::*;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int POOL_SIZE   = 24;
   localparam int HOME_COUNT  = 7;
   localparam int MAX_REPORTS = 10;
   // the limit allows the worst-case walk for some 620 items, taken several times over
   localparam int CYCLE_LIMIT = 1000000;

   // operation value with no meaning, answered as a miss
   localparam logic [1:0] OP_UNDEF = 2'd3;

   // how a probe walk ends
   typedef enum logic [1:0] {
      WALK_MATCH,
      WALK_EMPTY,
      WALK_FULL
   } walk_end_type;

   logic        clock;
   logic        reset;
   logic        req_push = 1'b0;
   lph_req_type req_item = '0;
   logic        req_full;
   logic        rsp_pop = 1'b0;
   lph_rsp_type rsp_item;
   logic        rsp_empty;

   // items waiting to be pushed, and answers waiting to come back, oldest first
   lph_req_type req_backlog[$];
   lph_rsp_type rsp_awaited[$];

   // shadow copy of the slot store
   logic                shadow_used[SLOTS];
   logic [KEY_W-1:0]    shadow_key[SLOTS];
   logic [HANDLE_W-1:0] shadow_handle[SLOTS];

   // keys that share a few home slots, so probe chains form and break
   logic [KEY_W-1:0] key_pool[POOL_SIZE];
   logic [KEY_W-1:0] fill_keys[SLOTS];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;

   linear_probe_hash_table_top #(
      .SLOTS(SLOTS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .rsp_pop  (rsp_pop),
      .rsp_item (rsp_item),
      .rsp_empty(rsp_empty)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // reset held high from the start and released once, never again
   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // run a single operation against the shadow table and return the answer it must give
   function automatic lph_rsp_type probe_and_update(input lph_req_type item);
      lph_rsp_type  answer;
      walk_end_type walk;
      int unsigned  idx;
      int unsigned  where;
      int unsigned  visited;
      answer.status       = ST_MISS;
      answer.found_handle = '0;
      answer.slot_index   = '0;
      if (item.operation == OP_UNDEF) begin
         return answer;
      end
      // walk forward from the home slot, wrapping, for at most SLOTS slots
      walk    = WALK_FULL;
      where   = 0;
      idx     = item.key % SLOTS;
      visited = 0;
      while (walk == WALK_FULL && visited < SLOTS) begin
         if (!shadow_used[idx]) begin
            walk  = WALK_EMPTY;
            where = idx;
         end else if (shadow_key[idx] == item.key) begin
            walk  = WALK_MATCH;
            where = idx;
         end else begin
            idx     = (idx + 1 == SLOTS) ? 0 : idx + 1;
            visited = visited + 1;
         end
      end
      if (walk == WALK_FULL) begin
         // no free slot and no match anywhere: nothing changes
         answer.status = ST_FULL;
      end else if (item.operation == OP_INSERT) begin
         // fills the free slot or overwrites the handle of the match
         shadow_used[where]   = 1'b1;
         shadow_key[where]    = item.key;
         shadow_handle[where] = item.record_handle;
         answer.status        = ST_OK;
         answer.slot_index    = where[SLOT_IDX_W-1:0];
      end else if (walk == WALK_MATCH) begin
         answer.status     = ST_OK;
         answer.slot_index = where[SLOT_IDX_W-1:0];
         if (item.operation == OP_SEARCH) begin
            answer.found_handle = shadow_handle[where];
         end else begin
            // remove leaves no tombstone
            shadow_used[where] = 1'b0;
         end
      end
      return answer;
   endfunction

   // count a failure, print only the first few
   function automatic void note_failure(input string what, input lph_rsp_type want,
                                        input lph_rsp_type got);
      fail_count = fail_count + 1;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t %s: expected status %0d handle %h slot %0d, got status %0d handle %h slot %0d",
                  $realtime, what, want.status, want.found_handle, want.slot_index,
                  got.status, got.found_handle, got.slot_index);
      end
   endfunction

   // driver: keeps an item on req_item until it is taken, idles at random between items
   always @(posedge clock) begin
      logic taken;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         taken = req_push && !req_full;
         if (taken) begin
            // the item goes in now: its answer joins the back of the line
            rsp_awaited.push_back(probe_and_update(req_item));
            void'(req_backlog.pop_front());
         end
         if (req_push && !taken) begin
            // blocked by full: hold the item as it is
         end else if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_item <= req_backlog[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor: pops at random, checks each answer against the oldest prediction
   always @(posedge clock) begin
      lph_rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (rsp_awaited.size() == 0) begin
               want = '0;
               note_failure("unexpected item", want, rsp_item);
            end else begin
               want = rsp_awaited.pop_front();
               if (rsp_item.status !== want.status ||
                   rsp_item.found_handle !== want.found_handle ||
                   rsp_item.slot_index !== want.slot_index) begin
                  note_failure("mismatch", want, rsp_item);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic queue_item(input logic [1:0] op, input logic [KEY_W-1:0] k,
                             input logic [HANDLE_W-1:0] h);
      lph_req_type item;
      item.operation     = op;
      item.key           = k;
      item.record_handle = h;
      req_backlog.push_back(item);
   endtask

   // random key whose home slot is the given one
   function automatic logic [KEY_W-1:0] key_at_home(input int unsigned home);
      int unsigned upper;
      upper = ($urandom() >> 1) / SLOTS;
      return KEY_W'(upper * SLOTS + home);
   endfunction

   // new key pool around a few home slots; the first and last slot are always among the homes
   task automatic refill_pool();
      int unsigned homes[HOME_COUNT];
      homes[0] = 0;
      homes[1] = SLOTS - 1;
      for (int i = 2; i < HOME_COUNT; i++) homes[i] = $urandom_range(SLOTS - 1);
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = key_at_home(homes[$urandom_range(HOME_COUNT - 1)]);
      end
   endtask

   // mostly pool keys so that hits, overwrites and broken chains happen; some stray keys
   task automatic queue_random(input int count);
      int               pick;
      logic [1:0]       op;
      logic [KEY_W-1:0] k;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         k    = key_pool[$urandom_range(POOL_SIZE - 1)];
         if ($urandom_range(9) == 0) k = KEY_W'($urandom());
         if (pick < 40) op = OP_INSERT;
         else if (pick < 70) op = OP_SEARCH;
         else if (pick < 95) op = OP_REMOVE;
         else op = OP_UNDEF;
         queue_item(op, k, $urandom());
      end
   endtask

   // sender holds off until every pushed item has been answered
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_push || rsp_awaited.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      int         pick;
      logic [1:0] op;
      for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
      @(negedge clock);

      // directed: empty table, extremes, wrap-around, overwrite, undefined op, broken chain
      set_idling(0, 0);
      queue_item(OP_SEARCH, '0, '0);
      queue_item(OP_REMOVE, '0, '1);
      queue_item(OP_INSERT, '0, '0);
      queue_item(OP_INSERT, '1, '1);
      // home is the last slot, taken: wraps past slot 0 into slot 1
      queue_item(OP_INSERT, KEY_W'(SLOTS - 1), 32'h1234_5678);
      queue_item(OP_SEARCH, KEY_W'(SLOTS - 1), '0);
      queue_item(OP_SEARCH, '1, '0);
      queue_item(OP_INSERT, '0, 32'hA5A5_A5A5);
      queue_item(OP_SEARCH, '0, '1);
      queue_item(OP_UNDEF, '0, '1);
      queue_item(OP_UNDEF, '1, '0);
      // freeing the head of the chain hides the wrapped key
      queue_item(OP_REMOVE, '1, '0);
      queue_item(OP_SEARCH, KEY_W'(SLOTS - 1), '0);
      queue_item(OP_SEARCH, KEY_W'(SLOTS), '0);
      queue_item(OP_REMOVE, KEY_W'(SLOTS - 1), '0);
      queue_item(OP_INSERT, KEY_W'(SLOTS - 1), 32'h5A5A_5A5A);
      queue_item(OP_SEARCH, KEY_W'(SLOTS - 1), '0);
      queue_item(OP_REMOVE, '0, '0);
      queue_item(OP_SEARCH, '0, '0);
      queue_item(OP_REMOVE, KEY_W'(SLOTS - 1), '0);
      queue_item(OP_SEARCH, '1, '0);
      wait_drained();

      // random phases, one idling pattern each
      refill_pool();
      queue_random(95);
      wait_drained();

      set_idling(52, 0);
      refill_pool();
      queue_random(95);
      wait_drained();

      set_idling(0, 52);
      refill_pool();
      queue_random(95);
      wait_drained();

      set_idling(15, 15);
      refill_pool();
      queue_random(95);
      wait_drained();

      // fill every slot, then work a full table: absent keys walk the whole store
      for (int i = 0; i < SLOTS; i++) begin
         fill_keys[i] = key_at_home(i);
         queue_item(OP_INSERT, fill_keys[i], $urandom());
      end
      for (int i = 0; i < 40; i++) begin
         pick = $urandom_range(99);
         if (pick < 30) op = OP_INSERT;
         else if (pick < 60) op = OP_SEARCH;
         else if (pick < 95) op = OP_REMOVE;
         else op = OP_UNDEF;
         if ($urandom_range(1) == 0) begin
            queue_item(op, fill_keys[$urandom_range(SLOTS - 1)], $urandom());
         end else begin
            queue_item(op, KEY_W'($urandom()), $urandom());
         end
      end
      // open a few gaps and carry on with a loaded table
      for (int i = 0; i < 20; i++) begin
         queue_item(OP_REMOVE, fill_keys[$urandom_range(SLOTS - 1)], $urandom());
      end
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = fill_keys[$urandom_range(SLOTS - 1)];
      queue_random(30);
      wait_drained();

      // let anything stray show up before the verdict
      repeat (SLOTS + 16) @(posedge clock);
      if (rsp_awaited.size() != 0) fail_count = fail_count + 1;
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
